/* design/bba_pkg.sv */
`default_nettype none

package bba_pkg;

  // Field and register widths
  localparam int CFG_W  = 17;
  localparam int BLK_W  = 16;
  localparam int WIDX_W = 11;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] TOTAL_RST     = 17'd65536;
  localparam logic [CFG_W-1:0] FIRST_RST     = 17'd1;
  localparam logic [CFG_W-1:0] INIT_FREE_RST = 17'd0;

  // Register indexes on the write port
  localparam logic [1:0] REG_VOL_BLOCKS = 2'd0;
  localparam logic [1:0] REG_FIRST_DATA = 2'd1;
  localparam logic [1:0] REG_INIT_FREE  = 2'd2;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_TEST  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_FREE_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EVAL,
    S_RESULT
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [BLK_W-1:0]   blk_id;
    logic [WIDX_W-1:0]  word_index;
    logic [DATA_W-1:0]  word_data;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   allocated_block;
    logic               bit_value;
    logic [CFG_W-1:0]   free_count;
  } rsp_t;

endpackage

`default_nettype wire

/* design/bba_stream_if.sv */
`default_nettype none

interface bba_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/bba_bitmap_ram.sv */
`default_nettype none

module bba_bitmap_ram #(
  parameter int AW = 11,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/bba_find_clear.sv */
`default_nettype none

module bba_find_clear #(
  parameter int WORD_BITS = 32,
  parameter int IW        = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [IW-1:0]        lo,
  input  wire logic [IW-1:0]        hi,
  output logic                      found,
  output logic      [IW-1:0]        idx
);

  // Pick the lowest clear bit inside the window lo..hi
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i] && (i >= int'(lo)) && (i <= int'(hi))) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* design/block_bitmap_allocator.sv */
// First-fit block allocator over a used/free bitmap held in one block RAM.
// Requests arrive on in_ch (func, blk_id, word_index, word_data) and
// each produces exactly one response on out_ch (status, allocated_block,
// bit_value, free_count). Registers are to be written through cfg_we/
// cfg_index/cfg_data only while no request is in flight, which the block
// does not enforce; index 3 is ignored. One request is worked on at a time.
// A load writes its word in the issue state; free and test read the RAM
// there and settle in the eval state; allocate scans in the eval state, one
// bitmap word per cycle from the RAM read port, at most MAX_BLOCKS/WORD_BITS
// words. An allocate whose first data block is at or past the bound skips the
// scan. A new request is taken in the cycle after the previous response enters the
// output register, even if that response has not yet been taken; the
// engine waits only if a finished response still finds the output
// register full. Reset clears the free counter, the handshakes and the
// registers to their defaults; bitmap contents are undefined until loaded.
`default_nettype none

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = 65536,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  bba_stream_if.sink                    in_ch,
  bba_stream_if.source                  out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [bba_pkg::CFG_W-1:0] cfg_data
);
  import bba_pkg::*;

  localparam int WORD_COUNT = MAX_BLOCKS / WORD_BITS;
  localparam int AW         = $clog2(WORD_COUNT);
  localparam int IW         = $clog2(WORD_BITS);

  // Configuration registers
  logic [CFG_W-1:0] vol_blocks;
  logic [CFG_W-1:0] first_data;
  logic [CFG_W-1:0] init_free;

  state_t           state, state_next;
  req_t             item;
  logic [AW-1:0]    ptr;
  logic [CFG_W-1:0] free_counter;
  status_t          res_status;
  logic [BLK_W-1:0] res_block;
  logic             res_bit;
  logic             out_valid;
  rsp_t             out_data;

  // Derived values
  logic [CFG_W-1:0]     lim, lim_m1, cap, blk_ext;
  logic [AW-1:0]        first_word, last_word, blk_word, ptr_inc;
  logic [IW-1:0]        blk_bit, win_lo, win_hi, hit_idx;
  logic                 alloc_possible, widx_ok, free_ok, test_bit, hit_found, out_free;
  logic [WORD_BITS-1:0] rdata, load_word;

  // RAM and handshake controls
  logic                 in_ready, out_load, mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  assign lim            = (32'(vol_blocks) < MAX_BLOCKS) ? vol_blocks : CFG_W'(MAX_BLOCKS);
  assign lim_m1         = lim - 1'b1;
  assign cap            = (vol_blocks > first_data) ? (vol_blocks - first_data) : '0;
  assign first_word     = AW'(first_data >> IW);
  assign last_word      = AW'(lim_m1 >> IW);
  assign blk_ext        = CFG_W'(item.blk_id);
  assign blk_word       = AW'(blk_ext >> IW);
  assign blk_bit        = blk_ext[IW-1:0];
  assign ptr_inc        = ptr + 1'b1;
  assign alloc_possible = first_data < lim;
  assign widx_ok        = 32'(item.word_index) < WORD_COUNT;
  assign load_word      = WORD_BITS'(item.word_data);
  assign free_ok        = (blk_ext >= first_data) && (blk_ext < lim) && rdata[blk_bit];
  assign test_bit       = (blk_ext >= lim) ? 1'b1 : rdata[blk_bit];
  assign win_lo         = (ptr == first_word) ? first_data[IW-1:0] : '0;
  assign win_hi         = (ptr == last_word) ? lim_m1[IW-1:0] : '1;
  assign out_free       = !out_valid || out_ch.ready;

  bba_bitmap_ram #(
    .AW (AW),
    .DW (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  bba_find_clear #(
    .WORD_BITS (WORD_BITS),
    .IW        (IW)
  ) u_find (
    .word  (rdata),
    .lo    (win_lo),
    .hi    (win_hi),
    .found (hit_found),
    .idx   (hit_idx)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (item.func == FN_LOAD || (item.func == FN_ALLOC && !alloc_possible)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (item.func != FN_ALLOC || hit_found || ptr == last_word) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs: handshake and RAM port controls
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = rdata;
    mem_raddr = ptr_inc;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_ISSUE: begin
        mem_raddr = (item.func == FN_ALLOC) ? first_word : blk_word;
        if (item.func == FN_LOAD) begin
          mem_we    = widx_ok;
          mem_waddr = AW'(item.word_index);
          mem_wdata = load_word;
        end
      end
      S_EVAL: begin
        if (item.func == FN_ALLOC && hit_found) begin
          mem_we    = 1'b1;
          mem_waddr = ptr;
          mem_wdata = rdata | (WORD_BITS'(1) << hit_idx);
        end else if (item.func == FN_FREE && free_ok) begin
          mem_we    = 1'b1;
          mem_waddr = blk_word;
          mem_wdata = rdata & ~(WORD_BITS'(1) << blk_bit);
        end
      end
      S_RESULT: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control state, counter and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_counter <= '0;
      out_valid    <= 1'b0;
      vol_blocks   <= TOTAL_RST;
      first_data   <= FIRST_RST;
      init_free    <= INIT_FREE_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // Preset on load of word 0, step on a grant or a release
      if (state == S_ISSUE && item.func == FN_LOAD && item.word_index == '0) begin
        free_counter <= init_free;
      end else if (state == S_EVAL && item.func == FN_ALLOC && hit_found
                   && free_counter != '0) begin
        free_counter <= free_counter - 1'b1;
      end else if (state == S_EVAL && item.func == FN_FREE && free_ok
                   && free_counter < cap) begin
        free_counter <= free_counter + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VOL_BLOCKS: vol_blocks <= cfg_data;
          REG_FIRST_DATA: first_data <= cfg_data;
          REG_INIT_FREE:  init_free  <= cfg_data;
          default:        init_free  <= init_free;
        endcase
      end
    end
  end

  // Request, scan pointer and response payload
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      item <= in_ch.payload;
    end
    if (state == S_ISSUE) begin
      ptr        <= first_word;
      res_status <= (item.func == FN_ALLOC && !alloc_possible) ? ST_NO_FREE : ST_DONE;
      res_block  <= '0;
      res_bit    <= 1'b0;
    end else if (state == S_EVAL) begin
      case (item.func)
        FN_ALLOC: begin
          if (hit_found) begin
            res_block <= BLK_W'({ptr, hit_idx});
          end else if (ptr == last_word) begin
            res_status <= ST_NO_FREE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        FN_FREE: begin
          if (!free_ok) begin
            res_status <= ST_FREE_IGNORED;
          end
        end
        FN_TEST: begin
          res_bit <= test_bit;
        end
        default: begin
          res_bit <= 1'b0;
        end
      endcase
    end
    if (out_load) begin
      out_data.status          <= res_status;
      out_data.allocated_block <= res_block;
      out_data.bit_value       <= res_bit;
      out_data.free_count      <= free_counter;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  // A transfer in starts the RAM read on the next cycle
  a_accept_issue: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_ISSUE)
    else $error("accepted request did not start");

  // The scan never runs past the last word of the bound
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL && item.func == FN_ALLOC |-> ptr <= last_word)
    else $error("scan pointer past bound");

  // No block is reported when nothing was free
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != ST_NO_FREE || out_data.allocated_block == '0))
    else $error("block reported with no-free status");

  // The RAM is written only while a request is being worked on
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_ISSUE || state == S_EVAL))
    else $error("bitmap write outside a request");

endmodule

`default_nettype wire

/* tb/block_bitmap_allocator_test.sv */
module block_bitmap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int WORDS      = 2048;
  localparam int WBITS      = 32;
  localparam int CAPACITY   = 65536;
  localparam int IDLE_LIMIT = 20000;

  // Mirror of the bitmap, the free counter and the registers; predicts one reply per request
  class bitmap_mirror;
    logic [31:0]      bitmap [WORDS];
    logic [CFG_W-1:0] free_cnt;
    logic [CFG_W-1:0] vol_blocks;
    logic [CFG_W-1:0] first_blk;
    logic [CFG_W-1:0] preset;
    rsp_t             expected_replies [$];
    int               errors;

    function new();
      free_cnt   = '0;
      vol_blocks = TOTAL_RST;
      first_blk  = FIRST_RST;
      preset     = INIT_FREE_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_VOL_BLOCKS: vol_blocks = val;
        REG_FIRST_DATA: first_blk  = val;
        REG_INIT_FREE:  preset     = val;
        default: ;
      endcase
    endfunction

    function int unsigned alloc_bound();
      return (vol_blocks < CAPACITY) ? vol_blocks : CAPACITY;
    endfunction

    // Out of range reads as used
    function logic bit_at(int unsigned b);
      if (b >= alloc_bound()) return 1'b1;
      return bitmap[b / WBITS][b % WBITS];
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned b;
      int unsigned lim;
      int unsigned cap;
      bit          found;
      e.status          = ST_DONE;
      e.allocated_block = '0;
      e.bit_value       = 1'b0;
      case (r.func)
        FN_LOAD: begin
          bitmap[r.word_index] = r.word_data;
          if (r.word_index == 0) free_cnt = preset;
        end
        FN_ALLOC: begin
          // First fit; skip whole used words to keep the scan cheap
          lim   = alloc_bound();
          b     = first_blk;
          found = 1'b0;
          while (b < lim && !found) begin
            if (b % WBITS == 0 && b + WBITS <= lim && bitmap[b / WBITS] == 32'hFFFF_FFFF)
              b += WBITS;
            else if (!bitmap[b / WBITS][b % WBITS])
              found = 1'b1;
            else
              b++;
          end
          if (found) begin
            bitmap[b / WBITS][b % WBITS] = 1'b1;
            if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
            e.allocated_block = 16'(b);
          end else begin
            e.status = ST_NO_FREE;
          end
        end
        FN_FREE: begin
          b = r.blk_id;
          if (b >= first_blk && b < vol_blocks && bit_at(b)) begin
            cap = (vol_blocks > first_blk) ? vol_blocks - first_blk : 0;
            bitmap[b / WBITS][b % WBITS] = 1'b0;
            if (free_cnt < cap) free_cnt = free_cnt + 1'b1;
          end else begin
            e.status = ST_FREE_IGNORED;
          end
        end
        default: e.bit_value = bit_at(r.blk_id);
      endcase
      e.free_count = free_cnt;
      expected_replies.push_back(e);
    endfunction

    function void check_reply(rsp_t got);
      rsp_t e;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply: status=%0d blk=%0d bit=%0d cnt=%0d",
                   got.status, got.allocated_block, got.bit_value, got.free_count);
        return;
      end
      e = expected_replies.pop_front();
      if (got.status !== e.status || got.allocated_block !== e.allocated_block ||
          got.bit_value !== e.bit_value || got.free_count !== e.free_count) begin
        errors++;
        if (errors <= 10)
          $display({"reply mismatch: exp status=%0d blk=%0d bit=%0d cnt=%0d, ",
                    "got status=%0d blk=%0d bit=%0d cnt=%0d"},
                   e.status, e.allocated_block, e.bit_value, e.free_count,
                   got.status, got.allocated_block, got.bit_value, got.free_count);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bba_stream_if #(.payload_t(req_t)) req_ch ();
  bba_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  block_bitmap_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  bitmap_mirror mirror;
  int           burst_left = 0;
  int           random_sent = 0;
  int           idle_cycles = 0;
  logic [15:0]  stall_pattern;
  int           pattern_age;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver: rotate a stall pattern, reload it each time pattern_age wraps
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready  <= 1'b0;
      stall_pattern <= 16'hFFFF;
      pattern_age   <= 0;
    end else begin
      rsp_ch.ready <= stall_pattern[0];
      if (pattern_age == 255) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'hB6DB;
          default: stall_pattern <= 16'($urandom) | 16'h0001;
        endcase
      end else begin
        pattern_age   <= pattern_age + 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // Check each reply transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) mirror.check_reply(rsp_ch.payload);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic req_t make_req(func_t f, logic [15:0] blk, logic [10:0] widx,
                                    logic [31:0] data);
    req_t r;
    r.func       = f;
    r.blk_id     = blk;
    r.word_index = widx;
    r.word_data  = data;
    return r;
  endfunction

  // Random request biased toward the active part of the bitmap
  function automatic req_t random_request();
    req_t        r;
    int unsigned lim;
    int unsigned lo_w;
    int unsigned hi_w;
    int unsigned pick;
    lim  = mirror.alloc_bound();
    hi_w = (lim == 0) ? 0 : (lim - 1) / WBITS;
    lo_w = (mirror.first_blk < lim) ? mirror.first_blk / WBITS : 0;
    r.blk_id     = 16'($urandom);
    r.word_index = 11'($urandom);
    r.word_data  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.func = FN_LOAD;
      pick   = $urandom_range(0, 9);
      if (pick < 7) r.word_index = 11'($urandom_range(lo_w, hi_w));
      else if (pick == 7) r.word_index = '0;
      case ($urandom_range(0, 7))
        0, 1: r.word_data = 32'hFFFF_FFFF;
        2:    r.word_data = 32'h0000_0000;
        3, 4: r.word_data = 32'hFFFF_FFFF ^ (32'h1 << $urandom_range(0, 31));
        default: ;
      endcase
    end else if (pick < 45) begin
      r.func = FN_ALLOC;
    end else begin
      r.func = (pick < 75) ? FN_FREE : FN_TEST;
      pick   = $urandom_range(0, 9);
      if (pick < 7 && mirror.first_blk < lim)
        r.blk_id = 16'($urandom_range(mirror.first_blk, lim - 1));
      else if (pick == 7)
        r.blk_id = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      else if (pick == 8 && lim < CAPACITY)
        r.blk_id = 16'($urandom_range(lim, CAPACITY - 1));
    end
    return r;
  endfunction

  // Offer one request; bursts of random length with gaps between them
  task automatic send(req_t r);
    int gap;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_request(r);
    burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted reply has come
  task automatic drain();
    if (burst_left != 0) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
    end
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    mirror.set_reg(idx, CFG_W'(val));
    @(posedge clk);
  endtask

  task automatic run_phase(int unsigned total, int unsigned first, int unsigned preset_val,
                           int n);
    write_reg(REG_VOL_BLOCKS, total);
    write_reg(REG_FIRST_DATA, first);
    write_reg(REG_INIT_FREE, preset_val);
    repeat (n) begin
      send(random_request());
      random_sent++;
      if (random_sent % 150 == 0) drain();
    end
  endtask

  initial begin
    int unsigned t;
    mirror         = new();
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_VOL_BLOCKS;
    cfg_data       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole bitmap: all used except the very last block
    write_reg(REG_INIT_FREE, 65536);
    for (int w = 1; w < WORDS; w++)
      send(make_req(FN_LOAD, 16'($urandom), 11'(w),
                    (w == WORDS - 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF));
    send(make_req(FN_LOAD, 16'hFFFF, 11'd0, 32'hFFFF_FFFF));

    // Full-range scan, exhaustion, saturation and ignored frees
    send(make_req(FN_TEST, 16'h0000, 11'h7FF, 32'h0));
    send(make_req(FN_TEST, 16'hFFFF, 11'h000, 32'h0));
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_ALLOC, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF));
    send(make_req(FN_TEST, 16'hFFFF, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'hFFFF, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'hFFFF, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'h0000, 11'h000, 32'h0));
    // Oversized preset, then grant from a cleared word
    send(make_req(FN_LOAD, 16'h0000, 11'h000, 32'h0000_0000));
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'h0001, 11'h000, 32'h0));
    // Counter at zero on allocate
    write_reg(REG_INIT_FREE, 0);
    send(make_req(FN_LOAD, 16'h0000, 11'h000, 32'h0000_0001));
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    // Smallest volume: no data block in range
    write_reg(REG_VOL_BLOCKS, 1);
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_TEST, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'h0000, 11'h000, 32'h0));
    // First data block at the top: nothing to allocate or free
    write_reg(REG_FIRST_DATA, 65536);
    write_reg(REG_VOL_BLOCKS, 65536);
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'hFFFF, 11'h000, 32'h0));
    // First data block zero: block 0 may be granted
    write_reg(REG_VOL_BLOCKS, 64);
    write_reg(REG_FIRST_DATA, 0);
    send(make_req(FN_LOAD, 16'h0000, 11'h000, 32'hFFFF_FFFE));
    send(make_req(FN_ALLOC, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_FREE, 16'h0000, 11'h000, 32'h0));
    send(make_req(FN_TEST, 16'd100, 11'h000, 32'h0));
    send(make_req(FN_TEST, 16'd63, 11'h000, 32'h0));

    // Random phases over several register settings
    run_phase(256, 1, 100, 250);
    run_phase(1000, 40, 0, 250);
    run_phase(64, 0, 65536, 200);
    run_phase(4096, 33, 2000, 250);
    run_phase(65536, 65500, 36, 150);
    run_phase(100, 500, 7, 80);
    run_phase(1, 1, 65536, 40);
    repeat (4) begin
      t = $urandom_range(32, 2048);
      run_phase(t, $urandom_range(0, t), $urandom_range(0, 65536), 120);
    end
    run_phase(65536, 1, 0, 12);

    drain();
    repeat (50) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
